[hw/rtl/aes_pkg.sv]
`timescale 1ns / 1ps
package aes_pkg;

  localparam int BlockWidth = 128;
  localparam int HalfWidth = 64;
  localparam int KeyStoreDepth = 30;
  localparam int KeyAddrWidth = $clog2(KeyStoreDepth);
  localparam int CfgIndexWidth = 3;

  localparam logic [CfgIndexWidth-1:0] RegKeyLength = 3'd0;
  localparam logic [CfgIndexWidth-1:0] RegKeyWordA = 3'd1;
  localparam logic [CfgIndexWidth-1:0] RegKeyWordB = 3'd2;
  localparam logic [CfgIndexWidth-1:0] RegKeyWordC = 3'd3;
  localparam logic [CfgIndexWidth-1:0] RegKeyWordD = 3'd4;

  localparam logic [1:0] KeyLen128 = 2'd0;
  localparam logic [1:0] KeyLen192 = 2'd1;

  // Datapath commands from the controller.
  typedef enum logic [2:0] {
    DpIdle,
    DpKeyLoad,
    DpKeyStep,
    DpBlockLoad,
    DpRound
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic decrypt;
    logic last_round;
    logic first_round;
    logic [3:0] round;
    logic [3:0] nr;
  } dp_cmd_t;

  typedef struct packed {
    logic key_done;
  } dp_status_t;

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] x, input logic [3:0] y);
    logic [7:0] a;
    logic [7:0] r;
    a = x;
    r = 8'h00;
    for (int i = 0; i < 4; i++) begin
      if (y[i]) r = r ^ a;
      a = xtime(a);
    end
    gmul = r;
  endfunction

  function automatic logic [7:0] gmul8(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] a;
    logic [7:0] r;
    a = x;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (y[i]) r = r ^ a;
      a = xtime(a);
    end
    gmul8 = r;
  endfunction

  function automatic logic [7:0] ginv(input logic [7:0] x);
    logic [7:0] r;
    logic [7:0] b;
    r = 8'h01;
    b = x;
    // x^254 by square and multiply over all 8 exponent bits
    for (int i = 0; i < 8; i++) begin
      if (i != 0) r = gmul8(r, b);
      b = gmul8(b, b);
    end
    ginv = r;
  endfunction

  function automatic logic [7:0] affine(input logic [7:0] v);
    affine = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]}
             ^ {v[3:0], v[7:4]} ^ 8'h63;
  endfunction

  // 256-entry byte tables, entry i at bits 8*i +: 8
  function automatic logic [2047:0] build_sbox_table(input logic inverse);
    logic [2047:0] tbl;
    logic [7:0]    s;
    tbl = '0;
    for (int i = 0; i < 256; i++) begin
      s = affine(ginv(8'(i)));
      if (inverse) tbl[8*s +: 8] = 8'(i);
      else tbl[8*i +: 8] = s;
    end
    build_sbox_table = tbl;
  endfunction

  localparam logic [2047:0] SboxTable = build_sbox_table(1'b0);
  localparam logic [2047:0] InvSboxTable = build_sbox_table(1'b1);

  function automatic logic [7:0] sbox(input logic [7:0] x);
    sbox = SboxTable[8*x +: 8];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] s);
    inv_sbox = InvSboxTable[8*s +: 8];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

endpackage

[hw/rtl/aes_ram.sv]
`timescale 1ns / 1ps
module aes_ram #(
  parameter int Width = 64,
  parameter int Depth = 30
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/aes_datapath.sv]
`timescale 1ns / 1ps
module aes_datapath
  import aes_pkg::*;
(
  input  logic                 clk,
  input  dp_cmd_t              cmd,
  input  logic [1:0]           key_length,
  input  logic [HalfWidth-1:0] key_word_a,
  input  logic [HalfWidth-1:0] key_word_b,
  input  logic [HalfWidth-1:0] key_word_c,
  input  logic [HalfWidth-1:0] key_word_d,
  input  logic [HalfWidth-1:0] block_high,
  input  logic [HalfWidth-1:0] block_low,
  input  logic [HalfWidth-1:0] key_rd_high,
  input  logic [HalfWidth-1:0] key_rd_low,
  output logic                 key_we,
  output logic [KeyAddrWidth-1:0] key_waddr,
  output logic [HalfWidth-1:0] key_wdata,
  output dp_status_t           status,
  output logic [BlockWidth-1:0] state
);
  // Key expansion: 8-word window, one word per cycle.
  logic [31:0] win [8];
  logic [5:0]  total;
  logic [3:0]  nk;
  logic [2:0]  nk_cnt;    // i mod nk
  logic [7:0]  rc;
  logic [31:0] t;
  logic [31:0] new_w;
  logic [31:0] pend;      // even word waiting for its pair
  logic [5:0]  emit;      // words written so far

  always_comb begin
    logic [31:0] prev;
    prev = win[3'(nk - 4'd1)];
    t = prev;
    if (nk_cnt == 3'd0) t = sub_word({prev[23:0], prev[31:24]}) ^ {rc, 24'h0};
    else if (nk == 4'd8 && nk_cnt == 3'd4) t = sub_word(prev);
    new_w = win[0] ^ t;
  end

  // Words leave the window oldest first; win[0] is word wi-nk.
  logic [31:0] out_w;
  logic        out_ok;
  always_comb begin
    out_w = win[0];
    out_ok = (emit < total) && (cmd.op == DpKeyStep);
  end

  assign key_we = out_ok && emit[0];
  assign key_waddr = emit[KeyAddrWidth:1];
  assign key_wdata = {pend, out_w};
  assign status.key_done = (emit >= total);

  // One round per cycle; each round key is read in the cycle before its round.
  logic [BlockWidth-1:0] round_out;
  logic [BlockWidth-1:0] rk;
  logic [7:0] s  [16];
  logic [7:0] sr [16];
  logic [7:0] sb [16];
  logic [7:0] mc [16];
  logic [7:0] ak [16];

  always_ff @(posedge clk) begin
    case (cmd.op)
      DpKeyLoad: begin
        win[0] <= key_word_a[63:32]; win[1] <= key_word_a[31:0];
        win[2] <= key_word_b[63:32]; win[3] <= key_word_b[31:0];
        win[4] <= key_word_c[63:32]; win[5] <= key_word_c[31:0];
        win[6] <= key_word_d[63:32]; win[7] <= key_word_d[31:0];
        if (key_length == KeyLen128) begin
          nk <= 4'd4; total <= 6'd44;
        end else if (key_length == KeyLen192) begin
          nk <= 4'd6; total <= 6'd52;
        end else begin
          nk <= 4'd8; total <= 6'd60;
        end
        nk_cnt <= 3'd0;
        rc <= 8'h01;
        emit <= 6'd0;
      end
      DpKeyStep: begin
        if (out_ok) begin
          for (int k = 0; k < 7; k++) win[k] <= win[k + 1];
          win[3'(nk - 4'd1)] <= new_w;
          if (nk_cnt == 3'd0) rc <= xtime(rc);
          nk_cnt <= (nk_cnt == 3'(nk - 4'd1)) ? 3'd0 : nk_cnt + 3'd1;
          pend <= out_w;
          emit <= emit + 6'd1;
        end
      end
      DpBlockLoad: begin
        state <= {block_high, block_low};
      end
      DpRound: begin
        state <= round_out;
      end
      default: begin
      end
    endcase
  end

  assign rk = {key_rd_high, key_rd_low};

  always_comb begin
    for (int i = 0; i < 16; i++) s[i] = state[127 - 8*i -: 8];
    for (int i = 0; i < 16; i++) begin
      sr[i] = 8'h0; sb[i] = 8'h0; mc[i] = 8'h0; ak[i] = 8'h0;
    end
    if (cmd.first_round) begin
      for (int i = 0; i < 16; i++) ak[i] = s[i] ^ rk[127 - 8*i -: 8];
    end else if (!cmd.decrypt) begin
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          sb[r + 4*c] = sbox(s[r + 4*((c + r) & 3)]);
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          mc[4*c + r] = cmd.last_round ? sb[4*c + r] :
            gmul(sb[4*c + r], 4'h2) ^ gmul(sb[4*c + ((r + 1) & 3)], 4'h3)
            ^ sb[4*c + ((r + 2) & 3)] ^ sb[4*c + ((r + 3) & 3)];
      for (int i = 0; i < 16; i++) ak[i] = mc[i] ^ rk[127 - 8*i -: 8];
    end else begin
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          sr[r + 4*((c + r) & 3)] = s[r + 4*c];
      for (int i = 0; i < 16; i++) sb[i] = inv_sbox(sr[i]) ^ rk[127 - 8*i -: 8];
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          ak[4*c + r] = cmd.last_round ? sb[4*c + r] :
            gmul(sb[4*c + r], 4'hE) ^ gmul(sb[4*c + ((r + 1) & 3)], 4'hB)
            ^ gmul(sb[4*c + ((r + 2) & 3)], 4'hD)
            ^ gmul(sb[4*c + ((r + 3) & 3)], 4'h9);
    end
    for (int i = 0; i < 16; i++) round_out[127 - 8*i -: 8] = ak[i];
  end
endmodule

[hw/rtl/aes_ctrl.sv]
`timescale 1ns / 1ps
module aes_ctrl
  import aes_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       func,
  input  logic       cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [1:0] key_length,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic [KeyAddrWidth-1:0] key_raddr,
  output logic       busy,
  output logic       done
);
  typedef enum logic [2:0] {
    Idle, KeyLoad, KeyStep, Load, Round
  } state_t;

  state_t     fsm;
  logic       ready;
  logic       dec;
  logic [3:0] round;
  logic [3:0] nr;
  logic       cfg_hit;

  assign cfg_hit = cfg_we && (cfg_index <= RegKeyWordD);

  // Round key index to read for a given step (0 = initial add).
  function automatic logic [3:0] key_idx(input logic d, input logic [3:0] step,
                                         input logic [3:0] n);
    key_idx = d ? n - step : step;
  endfunction

  logic [3:0] rk_idx;
  always_comb begin
    rk_idx = 4'd0;
    case (fsm)
      Load: rk_idx = key_idx(dec, 4'd0, nr);
      Round: rk_idx = key_idx(dec, round + 4'd1, nr);
      default: rk_idx = key_idx(func, 4'd0, nr);
    endcase
  end
  // both banks read the same even entry, one half each: see top level
  assign key_raddr = KeyAddrWidth'({rk_idx, 1'b0});

  always_comb begin
    cmd.op = DpIdle;
    case (fsm)
      Idle: cmd.op = start ? DpBlockLoad : DpIdle;  // block taken with the request
      KeyLoad: cmd.op = DpKeyLoad;
      KeyStep: cmd.op = DpKeyStep;
      Round: cmd.op = DpRound;
      default: cmd.op = DpIdle;
    endcase
    cmd.decrypt = dec;
    cmd.round = round;
    cmd.nr = nr;
    cmd.first_round = (round == 4'd0);
    cmd.last_round = (round == nr);
  end

  assign busy = (fsm != Idle);

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm <= Idle;
      ready <= 1'b0;
      done <= 1'b0;
      dec <= 1'b0;
      round <= 4'd0;
      nr <= 4'd10;
    end else begin
      done <= 1'b0;
      if (cfg_hit) ready <= 1'b0;
      case (fsm)
        Idle: begin
          if (start) begin
            dec <= func;
            nr <= (key_length == KeyLen128) ? 4'd10 :
                  (key_length == KeyLen192) ? 4'd12 : 4'd14;
            fsm <= ready ? Load : KeyLoad;
          end
        end
        KeyLoad: fsm <= KeyStep;
        KeyStep: begin
          if (status.key_done) begin
            ready <= 1'b1;
            fsm <= Load;
          end
        end
        Load: begin
          round <= 4'd0;
          fsm <= Round;
        end
        Round: begin
          round <= round + 4'd1;
          if (round == nr) begin
            done <= 1'b1;
            fsm <= Idle;
          end
        end
        default: fsm <= Idle;
      endcase
    end
  end
endmodule

[hw/rtl/aes_block_cipher.sv]
`timescale 1ns / 1ps
// AES block cipher, 128/192/256-bit keys, one round per clock. Write the key
// registers (index 0 key_length, 1..4 key words) only while busy is low. A
// request is taken when start is high and busy is low; the block is captured
// at that edge. busy stays high until the result appears with done for one
// cycle. The result must be captured in that cycle: the receiver cannot stall
// the block. A request passes from accept to the next accept through a
// key-prefetch state, the rounds in the single shared round unit, and the done
// cycle. The first request after reset or after any key register write first
// expands the key schedule into two 30 x 64 round-key RAM banks, one 32-bit
// word per cycle, before its rounds.
module aes_block_cipher
  import aes_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  output logic                     done,
  input  logic                     func,
  input  logic [HalfWidth-1:0]     block_high,
  input  logic [HalfWidth-1:0]     block_low,
  output logic [HalfWidth-1:0]     result_high,
  output logic [HalfWidth-1:0]     result_low,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [HalfWidth-1:0]     cfg_data
);
  logic [1:0]           key_length;
  logic [HalfWidth-1:0] key_word_a, key_word_b, key_word_c, key_word_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= 2'd0;
      key_word_a <= '0;
      key_word_b <= '0;
      key_word_c <= '0;
      key_word_d <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegKeyLength: key_length <= cfg_data[1:0];
        RegKeyWordA: key_word_a <= cfg_data;
        RegKeyWordB: key_word_b <= cfg_data;
        RegKeyWordC: key_word_c <= cfg_data;
        RegKeyWordD: key_word_d <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [KeyAddrWidth-1:0] key_raddr;
  logic                    key_we;
  logic [KeyAddrWidth-1:0] key_waddr;
  logic [HalfWidth-1:0]    key_wdata;
  logic [HalfWidth-1:0]    key_rd_high, key_rd_low;
  logic [BlockWidth-1:0]   state;

  aes_ctrl u_ctrl (
    .clk, .rst, .start, .func, .cfg_we, .cfg_index, .key_length,
    .status, .cmd, .key_raddr, .busy, .done
  );

  // Two banks hold the halves of each round key so one read gives a full key.
  aes_ram #(.Width(HalfWidth), .Depth(KeyStoreDepth)) u_rk_high (
    .clk, .we(key_we && !key_waddr[0]), .waddr(key_waddr), .wdata(key_wdata),
    .raddr(key_raddr), .rdata(key_rd_high)
  );
  aes_ram #(.Width(HalfWidth), .Depth(KeyStoreDepth)) u_rk_low (
    .clk, .we(key_we && key_waddr[0]), .waddr(key_waddr - KeyAddrWidth'(1)),
    .wdata(key_wdata), .raddr(key_raddr), .rdata(key_rd_low)
  );

  aes_datapath u_dp (
    .clk, .cmd, .key_length, .key_word_a, .key_word_b, .key_word_c, .key_word_d,
    .block_high, .block_low, .key_rd_high, .key_rd_low,
    .key_we, .key_waddr, .key_wdata, .status, .state
  );

  assign result_high = state[BlockWidth-1:HalfWidth];
  assign result_low  = state[HalfWidth-1:0];
endmodule

[hw/rtl/aes_checker.sv]
`timescale 1ns / 1ps
module aes_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than one cycle");
  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("busy after done");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request not taken");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without request");
endmodule

bind aes_block_cipher aes_checker u_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done)
);

[test/tb_aes_block_cipher.sv]
`timescale 1ns / 1ps
module tb_aes_block_cipher;
  import aes_pkg::*;

  // request: one cipher block plus direction
  typedef struct {
    logic             decrypt;
    logic [HalfWidth-1:0] hi;
    logic [HalfWidth-1:0] lo;
  } aes_req_t;

  localparam int WatchdogLimit = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic func = 1'b0;
  logic [HalfWidth-1:0] block_high = '0;
  logic [HalfWidth-1:0] block_low = '0;
  logic [HalfWidth-1:0] result_high, result_low;
  logic cfg_we = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [HalfWidth-1:0] cfg_data = '0;

  aes_block_cipher u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .func(func), .block_high(block_high), .block_low(block_low),
    .result_high(result_high), .result_low(result_low),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  aes_req_t pending_blocks[$];
  logic [127:0] expected_blocks[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  bit burst_mode = 0;
  logic took = 1'b0;

  // ---------------------------------------------------------------
  // Predictor state: its own copy of the key registers and schedule.
  // ---------------------------------------------------------------
  logic [1:0]  pr_keylen = KeyLen128;
  logic [63:0] pr_key[4] = '{default: '0};
  logic [31:0] pr_words[60];
  bit          pr_ready = 0;
  int          pr_rounds = 10;
  logic [7:0]  sb_fwd[256];
  logic [7:0]  sb_inv[256];
  logic [7:0]  st[16];

  function automatic logic [7:0] dbl(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [7:0] fmul(logic [7:0] x, logic [7:0] y);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (y[i]) acc ^= x;
      x = dbl(x);
    end
    return acc;
  endfunction

  // S-box from the field inverse (brute-force search) and the affine map
  task automatic build_sboxes();
    logic [7:0] inv, s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++)
        if (fmul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sb_fwd[x] = s;
      sb_inv[s] = x[7:0];
    end
  endtask

  function automatic logic [31:0] subw(logic [31:0] w);
    return {sb_fwd[w[31:24]], sb_fwd[w[23:16]], sb_fwd[w[15:8]], sb_fwd[w[7:0]]};
  endfunction

  task automatic expand_keys();
    int nk, total;
    logic [31:0] t;
    logic [7:0] rc;
    // code 3 behaves as 256-bit
    nk = (pr_keylen == 2'd0) ? 4 : (pr_keylen == 2'd1) ? 6 : 8;
    total = 4 * (nk + 7);
    rc = 8'h01;
    for (int i = 0; i < nk; i++)
      pr_words[i] = (i % 2) ? pr_key[i/2][31:0] : pr_key[i/2][63:32];
    for (int i = nk; i < total; i++) begin
      t = pr_words[i-1];
      if (i % nk == 0) begin
        t = subw({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = dbl(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = subw(t);
      end
      pr_words[i] = pr_words[i-nk] ^ t;
    end
    pr_rounds = nk + 6;
    pr_ready = 1;
  endtask

  task automatic add_round_key(int r);
    logic [31:0] w;
    for (int i = 0; i < 16; i++) begin
      w = pr_words[4*r + i/4];
      st[i] ^= w[31 - 8*(i%4) -: 8];
    end
  endtask

  task automatic sub_state(bit inverse);
    for (int i = 0; i < 16; i++) st[i] = inverse ? sb_inv[st[i]] : sb_fwd[st[i]];
  endtask

  task automatic shift_state(bit inverse);
    logic [7:0] t[16];
    t = st;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        if (inverse) st[r + 4*((c+r)%4)] = t[r + 4*c];
        else st[r + 4*c] = t[r + 4*((c+r)%4)];
      end
  endtask

  task automatic mix_state(bit inverse);
    logic [7:0] coef[4];
    logic [7:0] col[4];
    logic [7:0] acc;
    if (inverse) coef = '{8'h0E, 8'h0B, 8'h0D, 8'h09};
    else coef = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) col[j] = st[4*c + j];
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int j = 0; j < 4; j++) acc ^= fmul(coef[(j - r + 4) % 4], col[j]);
        st[4*c + r] = acc;
      end
    end
  endtask

  task automatic predict_aes(aes_req_t rq, output logic [127:0] res);
    logic [127:0] blk;
    if (!pr_ready) expand_keys();
    blk = {rq.hi, rq.lo};
    for (int i = 0; i < 16; i++) st[i] = blk[127 - 8*i -: 8];
    if (!rq.decrypt) begin
      add_round_key(0);
      for (int r = 1; r < pr_rounds; r++) begin
        sub_state(0); shift_state(0); mix_state(0); add_round_key(r);
      end
      sub_state(0); shift_state(0); add_round_key(pr_rounds);
    end else begin
      add_round_key(pr_rounds);
      for (int r = pr_rounds - 1; r > 0; r--) begin
        shift_state(1); sub_state(1); add_round_key(r); mix_state(1);
      end
      shift_state(1); sub_state(1); add_round_key(0);
    end
    for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = st[i];
  endtask

  // ---------------------------------------------------------------
  // Monitor: register writes, accepted requests and results, all at posedge.
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    aes_req_t rq;
    logic [127:0] exp_blk;
    logic [127:0] got;
    if (rst) begin
      took <= 1'b0;
    end else begin
      took <= start && !busy;
      if (cfg_we) begin
        case (cfg_index)
          RegKeyLength: begin pr_keylen = cfg_data[1:0]; pr_ready = 0; end
          RegKeyWordA:  begin pr_key[0] = cfg_data; pr_ready = 0; end
          RegKeyWordB:  begin pr_key[1] = cfg_data; pr_ready = 0; end
          RegKeyWordC:  begin pr_key[2] = cfg_data; pr_ready = 0; end
          RegKeyWordD:  begin pr_key[3] = cfg_data; pr_ready = 0; end
          default: ;  // out-of-range index: ignored, schedule kept
        endcase
      end
      if (start && !busy) begin
        rq.decrypt = func; rq.hi = block_high; rq.lo = block_low;
        predict_aes(rq, exp_blk);
        expected_blocks.push_back(exp_blk);
      end
      if (done) begin
        got = {result_high, result_low};
        if (expected_blocks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          exp_blk = expected_blocks.pop_front();
          if (got[127:64] !== exp_blk[127:64] || got[63:0] !== exp_blk[63:0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: exp %h_%h got %h_%h", exp_blk[127:64],
                       exp_blk[63:0], got[127:64], got[63:0]);
          end
        end
      end
      // watchdog on activity
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WatchdogLimit) begin
      $display("aes_block_cipher: mismatch");
      $finish;
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (burst_mode || p < 65) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // ---------------------------------------------------------------
  // Driver: at negedge; holds start until the previous posedge took it.
  // ---------------------------------------------------------------
  always @(negedge clk) begin
    aes_req_t rq;
    if (rst) begin
      start <= 1'b0;
    end else if (start && !took) begin
      // request still waiting for busy to drop
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (pending_blocks.size() > 0) begin
      rq = pending_blocks.pop_front();
      func <= rq.decrypt;
      block_high <= rq.hi;
      block_low <= rq.lo;
      start <= 1'b1;
      gap_left <= pick_gap();
    end else begin
      start <= 1'b0;
    end
  end

  // wait until the sender is drained and every result is back
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_blocks.size() != 0 || start || busy || expected_blocks.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIndexWidth-1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_req(logic d, logic [63:0] h, logic [63:0] l);
    aes_req_t rq;
    rq.decrypt = d; rq.hi = h; rq.lo = l;
    pending_blocks.push_back(rq);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] key_word_value();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return '0;
    if (p == 1) return '1;
    return rand64();
  endfunction

  initial begin
    logic [1:0] kl;
    build_sboxes();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset key (all-zero, 128-bit), extreme blocks both ways, one standard block
    queue_req(0, '0, '0);
    queue_req(1, '0, '0);
    queue_req(0, '1, '1);
    queue_req(1, '1, '1);
    queue_req(0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    wait_drained();

    // each key length code, standard and all-ones keys in turn, including unused code 3
    for (int k = 0; k < 4; k++) begin
      write_reg(RegKeyLength, 64'(k));
      write_reg(RegKeyWordA, (k % 2) ? '1 : 64'h0001020304050607);
      write_reg(RegKeyWordB, (k % 2) ? '1 : 64'h08090a0b0c0d0e0f);
      write_reg(RegKeyWordC, (k % 2) ? '1 : 64'h1011121314151617);
      write_reg(RegKeyWordD, (k % 2) ? '1 : 64'h18191a1b1c1d1e1f);
      end_writes();
      queue_req(0, 64'h0011223344556677, 64'h8899aabbccddeeff);
      queue_req(1, 64'h0011223344556677, 64'h8899aabbccddeeff);
      queue_req(1'(k % 2), '1, '0);
      wait_drained();
    end

    // out-of-range index: ignored, the schedule stays valid
    write_reg(3'd5, '1);
    write_reg(3'd7, rand64());
    end_writes();
    queue_req(0, '0, '1);
    queue_req(1, '0, '1);
    wait_drained();

    // random phases; the sender waits for all results between phases
    for (int ph = 0; ph < 9; ph++) begin
      burst_mode = (ph % 3 == 1);
      kl = (ph < 4) ? ph[1:0] : 2'($urandom_range(0, 3));
      if (ph < 4 || $urandom_range(0, 1)) write_reg(RegKeyLength, 64'(kl));
      if (ph < 4 || $urandom_range(0, 3) != 0) write_reg(RegKeyWordA, key_word_value());
      if (ph < 4 || $urandom_range(0, 3) != 0) write_reg(RegKeyWordB, key_word_value());
      if (ph < 4 || $urandom_range(0, 2) != 0) write_reg(RegKeyWordC, key_word_value());
      if (ph < 4 || $urandom_range(0, 2) != 0) write_reg(RegKeyWordD, key_word_value());
      if ($urandom_range(0, 3) == 0)
        write_reg(CfgIndexWidth'($urandom_range(5, 7)), rand64());
      end_writes();
      for (int n = 0; n < 150; n++) begin
        case ($urandom_range(0, 15))
          0: queue_req(1'($urandom_range(0, 1)), '0, '0);
          1: queue_req(1'($urandom_range(0, 1)), '1, '1);
          default: queue_req(1'($urandom_range(0, 1)), rand64(), rand64());
        endcase
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_blocks.size() == 0) begin
      $display("aes_block_cipher: match");
    end else begin
      $display("aes_block_cipher: mismatch");
    end
    $finish;
  end

endmodule
